FILE: design/tts_pkg.sv
// Shared types and constants for the tick to nanosecond timespec converter.
// Used by every module of the block but the checker; depends on nothing.
package tts_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SCALE_NUMER  = 2'd0,
    CFG_SCALE_DENOM  = 2'd1,
    CFG_SLEEP_OFFSET = 2'd2
  } cfg_index_t;

  // Conversion function codes; the unused code behaves as raw ticks.
  localparam logic [1:0] FUNC_RAW    = 2'd0;
  localparam logic [1:0] FUNC_OFFSET = 2'd1;
  localparam logic [1:0] FUNC_US     = 2'd2;

  localparam int FRAC_BITS = 34;
  localparam logic [63:0] UNITY_MULT = 64'h0000_0004_0000_0000;
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US  = 10'd1000;

  // floor(x / 125) equals (x * RECIP_125) >> 34 for every x below 2^27.
  localparam logic [27:0] RECIP_125 = 28'd137438954;

  // Seconds split: quotient bits resolved per stage and number of stages.
  localparam int SEC_STEPS  = 7;
  localparam int SEC_STAGES = 5;

  // Derived scale as seen by the datapath.
  typedef struct packed {
    logic [63:0] mult;
    logic        unity;
    logic        numer_zero;
  } scale_t;

  // Item after the nanosecond product.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] ns;
  } ns_item_t;

  // Item after the split into whole seconds and remainder.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] ns;
    logic [34:0] secs;
    logic [29:0] rem;
  } sec_item_t;

endpackage

FILE: design/tick_to_nanosecond_timespec.sv
// Top level of the tick to nanosecond timespec converter.
// Depends on tts_pkg, tts_scale_div, tts_ns_mul, tts_sec_div and tts_us_quant.
//
// Converts a 64-bit tick count into nanoseconds, whole seconds and a
// nanosecond remainder through eleven register stages, at one transaction per
// clock while the output is not stalled and the scale divider is idle. The
// datapath is a pipeline: offset add, 32x32 partial products, column sums,
// product assembly, five stages of long division by one billion (seven
// quotient bits each), and two stages of microsecond rounding. A write to
// scale_numer or scale_denom starts a bit-serial divider that derives the
// multiplier; while it runs s_tready stays low. The user must write
// configuration only when no transaction is in flight; the block itself
// does not enforce it.
module tick_to_nanosecond_timespec
  import tts_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Input stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // [63:0] tick_count
  input  logic [1:0]   s_tuser,   // [1:0] func
  // Output stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // [63:0] total_ns, [98:64] whole_seconds,
                                  // [128:99] subsec_ns, [159:129] resolution_ns
  output logic         m_tuser,   // [0] scale_error
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  scale_t      scale;
  logic [63:0] offset;
  logic        busy;
  logic        en;
  logic        ns_valid;
  ns_item_t    ns_item;
  logic        sec_valid;
  sec_item_t   sec_item;
  logic [63:0] total_ns;
  logic [34:0] whole_seconds;
  logic [29:0] subsec_ns;
  logic [30:0] resolution_ns;

  // The whole pipeline advances whenever the output register can move.
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en & ~busy;

  tts_scale_div u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scale     (scale),
    .offset    (offset),
    .busy      (busy)
  );

  tts_ns_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid & s_tready),
    .in_func   (s_tuser),
    .in_ticks  (s_tdata),
    .offset    (offset),
    .scale     (scale),
    .out_valid (ns_valid),
    .out_item  (ns_item)
  );

  tts_sec_div u_sec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ns_valid),
    .in_item   (ns_item),
    .out_valid (sec_valid),
    .out_item  (sec_item)
  );

  tts_us_quant u_quant (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (sec_valid),
    .in_item       (sec_item),
    .out_valid     (m_tvalid),
    .total_ns      (total_ns),
    .whole_seconds (whole_seconds),
    .subsec_ns     (subsec_ns)
  );

  // Resolution is the multiplier rounded up to whole nanoseconds per tick.
  assign resolution_ns = {1'b0, scale.mult[63:FRAC_BITS]} +
                         {30'd0, (scale.mult[FRAC_BITS-1:0] != '0)};

  assign m_tdata = {resolution_ns, subsec_ns, whole_seconds, total_ns};
  assign m_tuser = scale.numer_zero;

endmodule

FILE: design/tts_scale_div.sv
// Configuration registers and the serial divider that derives the 30.34
// fixed-point multiplier from numer/denom. Depends on tts_pkg.
module tts_scale_div
  import tts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output scale_t      scale,
  output logic [63:0] offset,
  output logic        busy
);

  logic [31:0] numer;
  logic [31:0] denom;
  logic [63:0] mult;
  logic        start;
  logic        running;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dsr;
  logic        big;

  logic [31:0] dsr_eff;
  logic [63:0] dividend;
  logic [32:0] rem_shift;
  logic        ge;
  logic [32:0] rem_sub;
  logic [31:0] rem_next;
  logic [63:0] quo_next;

  // Dividend setup: a zero denominator counts as one.
  always_comb begin
    dsr_eff = (denom == 32'd0) ? 32'd1 : denom;
    if (numer[31:30] == 2'b00) begin
      dividend = {numer[29:0], 34'd0} + {33'd0, dsr_eff[31:1]};
    end else begin
      dividend = {numer, 32'd0} + {33'd0, dsr_eff[31:1]};
    end
  end

  // One restoring division step per cycle.
  always_comb begin
    rem_shift = {rem, quo[63]};
    ge        = (rem_shift >= {1'b0, dsr});
    rem_sub   = rem_shift - {1'b0, dsr};
    rem_next  = ge ? rem_sub[31:0] : rem_shift[31:0];
    quo_next  = {quo[62:0], ge};
  end

  // Register writes and divider sequencing; a new scale write restarts it.
  always_ff @(posedge clk) begin
    if (rst) begin
      numer   <= 32'd1;
      denom   <= 32'd1;
      offset  <= 64'd0;
      mult    <= UNITY_MULT;
      start   <= 1'b0;
      running <= 1'b0;
      cnt     <= 6'd0;
    end else begin
      start <= cfg_we && (cfg_index == CFG_SCALE_NUMER || cfg_index == CFG_SCALE_DENOM);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE_NUMER:  numer  <= cfg_data[31:0];
          CFG_SCALE_DENOM:  denom  <= cfg_data[31:0];
          CFG_SLEEP_OFFSET: offset <= cfg_data;
          default: ;
        endcase
      end
      if (start) begin
        running <= 1'b1;
        cnt     <= 6'd0;
        rem     <= 32'd0;
        quo     <= dividend;
        dsr     <= dsr_eff;
        big     <= (numer[31:30] != 2'b00);
      end else if (running) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          mult    <= big ? {quo_next[61:0], 2'b00} : quo_next;
        end
      end
    end
  end

  assign busy             = start | running;
  assign scale.mult       = mult;
  assign scale.unity      = (mult == UNITY_MULT);
  assign scale.numer_zero = (numer == 32'd0);

endmodule

FILE: design/tts_ns_mul.sv
// Offset add and 64x64 product cut into 32x32 partial products over four
// stages, giving nanoseconds from ticks. Depends on tts_pkg.
module tts_ns_mul
  import tts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_ticks,
  input  logic [63:0] offset,
  input  scale_t      scale,
  output logic        out_valid,
  output ns_item_t    out_item
);

  logic        a_valid, b_valid, c_valid;
  logic [1:0]  a_func, b_func, c_func;
  logic [63:0] a_ticks, b_ticks, c_ticks;
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [33:0] c_t;
  logic [31:0] c_h;
  logic [31:0] mid_hi;

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // Stage A: ticks plus the sleep offset for the continuous modes.
  always_ff @(posedge clk) begin
    if (en) begin
      a_func  <= in_func;
      a_ticks <= (in_func == FUNC_OFFSET || in_func == FUNC_US) ?
                 in_ticks + offset : in_ticks;
    end
  end

  // Stage B: four partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      b_func  <= a_func;
      b_ticks <= a_ticks;
      pp_ll   <= a_ticks[31:0]  * scale.mult[31:0];
      pp_lh   <= a_ticks[31:0]  * scale.mult[63:32];
      pp_hl   <= a_ticks[63:32] * scale.mult[31:0];
      pp_hh   <= a_ticks[63:32] * scale.mult[63:32];
    end
  end

  // Stage C: column sums; only the low half of the upper word survives.
  always_ff @(posedge clk) begin
    if (en) begin
      c_func  <= b_func;
      c_ticks <= b_ticks;
      c_t     <= {2'b00, pp_ll[63:32]} + {2'b00, pp_lh[31:0]} + {2'b00, pp_hl[31:0]};
      c_h     <= pp_hh[31:0] + pp_lh[63:32] + pp_hl[63:32];
    end
  end

  // Stage D: middle word shifted by two, or the ticks at unity scale.
  assign mid_hi = c_h + {30'd0, c_t[33:32]};

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.func <= c_func;
      out_item.ns   <= scale.unity ? c_ticks : {2'b00, mid_hi, c_t[31:2]};
    end
  end

endmodule

FILE: design/tts_sec_div.sv
// Split of nanoseconds into whole seconds and remainder by long division
// by one billion, a few quotient bits per stage. Depends on tts_pkg.
module tts_sec_div
  import tts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  ns_item_t  in_item,
  output logic      out_valid,
  output sec_item_t out_item
);

  logic      st_valid [0:SEC_STAGES];
  sec_item_t st_item  [0:SEC_STAGES];

  // The top bits of the value are below one billion and seed the remainder.
  always_comb begin
    st_valid[0]      = in_valid;
    st_item[0].func  = in_item.func;
    st_item[0].ns    = in_item.ns;
    st_item[0].secs  = 35'd0;
    st_item[0].rem   = {1'b0, in_item.ns[63:35]};
  end

  for (genvar g = 0; g < SEC_STAGES; g++) begin : g_stage
    sec_item_t nxt;

    // Several restoring steps on the narrow remainder.
    always_comb begin
      logic [30:0] r2;
      nxt = st_item[g];
      for (int i = 0; i < SEC_STEPS; i++) begin
        r2 = {nxt.rem, nxt.ns[34 - g * SEC_STEPS - i]};
        if (r2 >= {1'b0, NS_PER_SEC}) begin
          r2 = r2 - {1'b0, NS_PER_SEC};
          nxt.secs = {nxt.secs[33:0], 1'b1};
        end else begin
          nxt.secs = {nxt.secs[33:0], 1'b0};
        end
        nxt.rem = r2[29:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[g+1] <= 1'b0;
      end else if (en) begin
        st_valid[g+1] <= st_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_item[g+1] <= nxt;
      end
    end
  end

  assign out_valid = st_valid[SEC_STAGES];
  assign out_item  = st_item[SEC_STAGES];

endmodule

FILE: design/tts_us_quant.sv
// Rounding down to whole microseconds for the quantized mode, ending in the
// output register. Depends on tts_pkg.
module tts_us_quant
  import tts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  sec_item_t   in_item,
  output logic        out_valid,
  output logic [63:0] total_ns,
  output logic [34:0] whole_seconds,
  output logic [29:0] subsec_ns
);

  logic        f_valid;
  sec_item_t   f_item;
  logic [19:0] f_us;
  logic [54:0] prod;
  logic [29:0] us_ns;
  logic [29:0] sub_us;

  // Stage F: microsecond count of the remainder by reciprocal multiply.
  assign prod = in_item.rem[29:3] * RECIP_125;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f_valid   <= in_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_item <= in_item;
      f_us   <= prod[53:34];
    end
  end

  // Stage G: drop the sub-microsecond part in the quantized mode.
  assign us_ns  = f_us * NS_PER_US;
  assign sub_us = f_item.rem - us_ns;

  always_ff @(posedge clk) begin
    if (en) begin
      whole_seconds <= f_item.secs;
      if (f_item.func == FUNC_US) begin
        total_ns  <= f_item.ns - {34'd0, sub_us};
        subsec_ns <= us_ns;
      end else begin
        total_ns  <= f_item.ns;
        subsec_ns <= f_item.rem;
      end
    end
  end

endmodule

FILE: design/tts_checker.sv
// Port-level checker for the tick to nanosecond timespec converter, bound to
// the top level. Depends only on the top level's ports.
module tts_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [159:0] m_tdata,
  input logic         m_tuser
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transaction dropped while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output data changed while stalled");

  // Seconds and remainder rebuild the total and the remainder is in range.
  a_split: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[128:99] < 30'd1000000000) &&
      ({29'd0, m_tdata[98:64]} * 64'd1000000000 + {34'd0, m_tdata[128:99]}
       == m_tdata[63:0]))
    else $error("seconds split does not match total");

  // A missing scale yields all-zero results.
  a_scale_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == 160'd0))
    else $error("nonzero result with scale error");

endmodule

bind tick_to_nanosecond_timespec tts_checker u_tts_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: verif/tb.sv
// Self-checking bench for the tick to nanosecond timespec converter.
// Depends on tts_pkg and tick_to_nanosecond_timespec; predicts each result in place.
module tb;
  import tts_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] ticks;
  } tick_item_t;

  typedef struct packed {
    logic [63:0] total_ns;
    logic [34:0] secs;
    logic [29:0] subsec;
    logic [30:0] res;
    logic        err;
  } timespec_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  tick_item_t pending_ticks[$];
  timespec_t  expected_times[$];
  logic [31:0] numer_q;
  logic [31:0] denom_q;
  logic [63:0] offset_q;
  logic [63:0] mult_q;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  // Recompute the fixed-point multiplier from the current ratio.
  function automatic void derive_mult();
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    d = (denom_q == 0) ? 128'd1 : {96'd0, denom_q};
    n = {96'd0, numer_q};
    if (numer_q < 32'h4000_0000) begin
      q = ((n << 34) + (d >> 1)) / d;
      mult_q = q[63:0];
    end else begin
      q = ((n << 32) + (d >> 1)) / d;
      mult_q = q[63:0] << 2;
    end
  endfunction

  function automatic timespec_t convert_ticks(tick_item_t it);
    timespec_t r;
    logic [63:0] t;
    logic [127:0] p;
    logic [63:0] ns;
    t = it.ticks;
    if (it.func == FUNC_OFFSET || it.func == FUNC_US) t = t + offset_q;
    p = {64'd0, t} * {64'd0, mult_q};
    ns = (mult_q == UNITY_MULT) ? t : {2'b00, p[95:34]};
    if (it.func == FUNC_US) ns = (ns / 64'd1000) * 64'd1000;
    r.total_ns = ns;
    r.secs = 35'(ns / 64'd1000000000);
    r.subsec = 30'(ns % 64'd1000000000);
    r.res = 31'((mult_q >> 34) + ((mult_q[33:0] != 0) ? 1 : 0));
    r.err = (numer_q == 0);
    return r;
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCALE_NUMER) begin
      numer_q = val[31:0];
      derive_mult();
    end else if (idx == CFG_SCALE_DENOM) begin
      denom_q = val[31:0];
      derive_mult();
    end else if (idx == CFG_SLEEP_OFFSET) begin
      offset_q = val;
    end
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      1: v = 64'($urandom_range(0, 2000));
      2: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_ticks(logic [1:0] f, logic [63:0] t);
    tick_item_t it;
    it.func = f;
    it.ticks = t;
    pending_ticks.push_back(it);
  endtask

  // Let the queue drain, then wait out the pipeline.
  task automatic drain();
    while (pending_ticks.size() != 0 || expected_times.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Driver: bursts of offers with random gaps. An accepted transaction is
  // removed from the queue first, so the head is always the next offer.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_times.push_back(convert_ticks(pending_ticks.pop_front()));
      end
      if (s_tvalid && !(s_tready)) begin
        // hold the current offer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        tick_item_t nxt;
        nxt = pending_ticks[0];
        s_tvalid <= 1'b1;
        s_tdata <= nxt.ticks;
        s_tuser <= nxt.func;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= (hold_left == 1);
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare every output transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      timespec_t e;
      if (expected_times.size() == 0) begin
        $error("unexpected result total_ns=%0h", m_tdata[63:0]);
        errors++;
      end else begin
        e = expected_times.pop_front();
        if (m_tdata[63:0] !== e.total_ns) begin
          $error("total_ns exp %0h got %0h", e.total_ns, m_tdata[63:0]); errors++;
        end
        if (m_tdata[98:64] !== e.secs) begin
          $error("whole_seconds exp %0d got %0d", e.secs, m_tdata[98:64]); errors++;
        end
        if (m_tdata[128:99] !== e.subsec) begin
          $error("subsec_ns exp %0d got %0d", e.subsec, m_tdata[128:99]); errors++;
        end
        if (m_tdata[159:129] !== e.res) begin
          $error("resolution_ns exp %0d got %0d", e.res, m_tdata[159:129]); errors++;
        end
        if (m_tuser !== e.err) begin
          $error("scale_error exp %0b got %0b", e.err, m_tuser); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("[tick_to_nanosecond_timespec] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] numers[6];
    logic [31:0] denoms[6];
    numer_q = 32'd1;
    denom_q = 32'd1;
    offset_q = 64'd0;
    derive_mult();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, all function codes, offset wrap, unity bypass.
    queue_ticks(FUNC_RAW, 64'd0);
    queue_ticks(FUNC_RAW, '1);
    queue_ticks(2'd3, 64'd123456789012);
    queue_ticks(FUNC_OFFSET, '1);
    queue_ticks(FUNC_US, 64'd999999999999);
    drain();
    write_reg(CFG_SLEEP_OFFSET, '1);
    write_reg(CFG_SCALE_NUMER, 64'd125);
    write_reg(CFG_SCALE_DENOM, 64'd3);
    queue_ticks(FUNC_OFFSET, 64'd5);
    queue_ticks(FUNC_US, 64'd0);
    queue_ticks(FUNC_US, '1);
    queue_ticks(FUNC_RAW, 64'h5555_5555_5555_5555);
    queue_ticks(2'd3, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();
    // Zero numerator, then zero denominator with a large numerator.
    write_reg(CFG_SCALE_NUMER, 64'd0);
    queue_ticks(FUNC_RAW, 64'd77);
    queue_ticks(FUNC_US, '1);
    drain();
    write_reg(CFG_SCALE_NUMER, 64'hFFFF_FFFF_0000_0000 | 64'hFFFF_FFFF);
    write_reg(CFG_SCALE_DENOM, 64'd0);
    queue_ticks(FUNC_RAW, '1);
    queue_ticks(FUNC_OFFSET, 64'd1);
    queue_ticks(FUNC_US, 64'h1234_5678_9ABC_DEF0);
    drain();

    // Random phases over several ratios.
    numers = '{32'd1, 32'd125, 32'h4000_0000, 32'd1000000000, 32'd41, 32'hFFFF_FFFF};
    denoms = '{32'd1, 32'd3, 32'd7, 32'd24000000, 32'hFFFF_FFFF, 32'd1};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) begin
        write_reg(CFG_SCALE_NUMER, {$urandom, numers[ph]});
        write_reg(CFG_SCALE_DENOM, {$urandom, denoms[ph]});
      end else begin
        write_reg(CFG_SCALE_NUMER, {32'd0, $urandom});
        write_reg(CFG_SCALE_DENOM, {32'd0, $urandom});
      end
      write_reg(CFG_SLEEP_OFFSET, rand64());
      for (int i = 0; i < 115; i++) begin
        queue_ticks(2'($urandom_range(0, 3)), rand64());
      end
      if (ph == 2) begin
        @(posedge clk);
        long_hold <= 1'b1;
      end
      drain();
    end

    if (errors == 0) begin
      $display("[tick_to_nanosecond_timespec] OK");
    end else begin
      $display("[tick_to_nanosecond_timespec] ERROR");
    end
    $finish;
  end

  tick_to_nanosecond_timespec uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );
endmodule
